// File: design/sapa_pkg.sv
// Shared types and constants for the sticky address pool allocator.
// Used by sapa_store and sticky_address_pool_allocator; depends on nothing.
package sapa_pkg;

    // Pool size and derived widths
    localparam int POOL_ENTRIES = 256;
    localparam int IDX_W        = $clog2(POOL_ENTRIES);
    localparam int CNT_W        = $clog2(POOL_ENTRIES + 1);
    localparam int ADDR_W       = 48;
    localparam int OUT_IDX_W    = 8;

    // Command codes carried on the input tuser
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // One pool entry as stored. While an entry is held, its holder is always
    // the address it was last bound to, so one address field serves both.
    typedef struct packed {
        logic              held;
        logic              used;
        logic [ADDR_W-1:0] owner;
    } entry_t;

    // Write request from the sequencer to the entry store
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        entry_t           data;
    } wr_req_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    // Low eight bits of an entry number, zero extended for small pools.
    function automatic logic [OUT_IDX_W-1:0] out_index(input logic [IDX_W-1:0] idx);
        logic [IDX_W+OUT_IDX_W-1:0] wide;
        wide = {{OUT_IDX_W{1'b0}}, idx};
        return wide[OUT_IDX_W-1:0];
    endfunction

endpackage

// File: design/sapa_store.sv
// Entry store of the pool allocator: one synchronous memory with a
// registered read, and per-entry valid bits cleared at reset.
// Depends on sapa_pkg.
module sapa_store
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [sapa_pkg::IDX_W-1:0]   rd_idx,
    output sapa_pkg::entry_t             rd_entry,
    input  sapa_pkg::wr_req_t            wr
);

    sapa_pkg::entry_t                    mem_ram [sapa_pkg::POOL_ENTRIES];
    logic [sapa_pkg::POOL_ENTRIES-1:0]   valid_reg;
    sapa_pkg::entry_t                    rd_data_reg;
    logic                                rd_valid_reg;

    // Memory write and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_ram[wr.idx] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_ram[rd_idx];
        end
    end

    // Valid bits: an entry never written since reset reads as all zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
        end
    end

    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: design/sticky_address_pool_allocator.sv
// Sticky address pool allocator: a request or a release keyed by a 48-bit client
// address. An accepted item is handled by a sweep reading one entry a cycle, the
// end of the search and a write-back; a request's word appears with the write-back.
// A new item is taken only once the last one is through, and an unread result word
// holds a request's write-back until taken.
// Reset clears all entry valid bits at once, so no clearing pass is needed.
module sticky_address_pool_allocator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // client_addr[47:0]
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // pool_index[7:0]
    output logic        m_tuser    // granted
);

    localparam logic [sapa_pkg::CNT_W-1:0] SCAN_END = sapa_pkg::CNT_W'(sapa_pkg::POOL_ENTRIES);

    sapa_pkg::state_t                  state_reg, state_next;
    logic                              cmd_reg, cmd_next;
    logic [sapa_pkg::ADDR_W-1:0]       addr_reg, addr_next;
    logic [sapa_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                              rd_pend_reg, rd_pend_next;
    logic [sapa_pkg::IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                              hit_found_reg, hit_found_next;
    logic [sapa_pkg::IDX_W-1:0]        hit_idx_reg, hit_idx_next;
    logic                              unused_found_reg, unused_found_next;
    logic [sapa_pkg::IDX_W-1:0]        unused_idx_reg, unused_idx_next;
    logic                              free_found_reg, free_found_next;
    logic [sapa_pkg::IDX_W-1:0]        free_idx_reg, free_idx_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic                              m_tuser_reg, m_tuser_next;
    logic [7:0]                        m_tdata_reg, m_tdata_next;

    logic                              rd_en;
    logic [sapa_pkg::IDX_W-1:0]        rd_idx;
    sapa_pkg::entry_t                  rd_entry;
    sapa_pkg::wr_req_t                 wr_req;
    logic                              scan_done;
    logic                              finish;
    logic                              load_out;
    logic                              is_req;
    logic                              addr_eq;
    logic                              tgt_found;
    logic [sapa_pkg::IDX_W-1:0]        tgt_idx;

    sapa_store u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry),
        .wr       (wr_req)
    );

    // Shared decode of the current item and the chosen target entry.
    assign is_req    = (cmd_reg == sapa_pkg::CMD_REQUEST);
    assign addr_eq   = (rd_entry.owner == addr_reg);
    assign tgt_found = hit_found_reg || (is_req && (unused_found_reg || free_found_reg));
    assign tgt_idx   = hit_found_reg    ? hit_idx_reg :
                       unused_found_reg ? unused_idx_reg : free_idx_reg;
    assign scan_done = (cnt_reg == SCAN_END) && !rd_pend_reg;
    assign finish    = (state_reg == sapa_pkg::ST_WRITE) &&
                       (!is_req || !m_tvalid_reg || m_tready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sapa_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = sapa_pkg::ST_SCAN;
                end
            end
            sapa_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = sapa_pkg::ST_WRITE;
                end
            end
            sapa_pkg::ST_WRITE:
            begin
                if (finish)
                begin
                    state_next = sapa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sapa_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: input handshake, memory reads and the write-back.
    always_comb
    begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        wr_req   = '0;
        load_out = 1'b0;
        unique case (state_reg)
            sapa_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            sapa_pkg::ST_SCAN:
            begin
                rd_en = (cnt_reg != SCAN_END);
            end
            sapa_pkg::ST_WRITE:
            begin
                // Requests bind and hold; releases drop the hold but keep the owner.
                wr_req.en         = finish && tgt_found;
                wr_req.idx        = tgt_idx;
                wr_req.data.held  = is_req;
                wr_req.data.used  = 1'b1;
                wr_req.data.owner = addr_reg;
                load_out          = finish && is_req;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign rd_idx = cnt_reg[sapa_pkg::IDX_W-1:0];

    // Sweep counter, lowest-first search and the output word.
    always_comb
    begin
        cmd_next          = cmd_reg;
        addr_next         = addr_reg;
        cnt_next          = cnt_reg;
        rd_pend_next      = rd_en;
        rd_idx_next       = rd_idx;
        hit_found_next    = hit_found_reg;
        hit_idx_next      = hit_idx_reg;
        unused_found_next = unused_found_reg;
        unused_idx_next   = unused_idx_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tuser_next      = m_tuser_reg;
        m_tdata_next      = m_tdata_reg;

        if (s_tvalid && s_tready)
        begin
            cmd_next          = s_tuser;
            addr_next         = s_tdata;
            cnt_next          = '0;
            hit_found_next    = 1'b0;
            unused_found_next = 1'b0;
            free_found_next   = 1'b0;
        end

        if (rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        // Examine the entry read last cycle; only the first match of each kind counts.
        if (rd_pend_reg)
        begin
            if (!hit_found_reg &&
                (is_req ? (rd_entry.used && addr_eq) : (rd_entry.held && addr_eq)))
            begin
                hit_found_next = 1'b1;
                hit_idx_next   = rd_idx_reg;
            end
            if (!unused_found_reg && !rd_entry.used)
            begin
                unused_found_next = 1'b1;
                unused_idx_next   = rd_idx_reg;
            end
            if (!free_found_reg && !rd_entry.held)
            begin
                free_found_next = 1'b1;
                free_idx_next   = rd_idx_reg;
            end
        end

        if (load_out)
        begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = tgt_found;
            m_tdata_next  = tgt_found ? sapa_pkg::out_index(tgt_idx) : '0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sapa_pkg::ST_IDLE;
            cnt_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_pend_reg  <= rd_pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        addr_reg         <= addr_next;
        rd_idx_reg       <= rd_idx_next;
        hit_found_reg    <= hit_found_next;
        hit_idx_reg      <= hit_idx_next;
        unused_found_reg <= unused_found_next;
        unused_idx_reg   <= unused_idx_next;
        free_found_reg   <= free_found_next;
        free_idx_reg     <= free_idx_next;
        m_tuser_reg      <= m_tuser_next;
        m_tdata_reg      <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    // The store is only written back once the sweep has finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_req.en |-> (state_reg == sapa_pkg::ST_WRITE))
        else $error("entry write outside write-back");

    // Read data is only in flight during the sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sapa_pkg::ST_SCAN) |-> !rd_pend_reg)
        else $error("memory read pending outside sweep");

    // A refused request always reports entry zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 8'd0))
        else $error("nonzero index on refused request");

    // A new result is only loaded when the previous word has gone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && m_tvalid_reg) |-> m_tready)
        else $error("result word overwritten");

endmodule
